>>> hdl/epc_pkg.sv
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, stage count and division constants for the epoch to civil
// date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package epc_pkg;

	localparam int NSTG = 15;

	typedef logic [NSTG:1] stg_en_t;

	// accepted ms range that truncates into years 1..9999
	localparam logic signed [48:0] MS_MIN = -49'sd62135596800999;
	localparam logic signed [48:0] MS_MAX = 49'sd253402300799999;
	// shift to 0001-01-01 00:00:00.000
	localparam logic [49:0] MS_OFS = 50'd62135596800000;
	localparam logic [49:0] MS_OFS_NEG = 50'd62135596800999;

	// ms per day = 2^10 * DAY_DIV
	localparam logic [16:0] DAY_DIV = 17'd84375;
	localparam logic [63:0] DAY_K64 = (64'd1 << 39) / 64'd84375;
	localparam logic [22:0] DAY_K = DAY_K64[22:0];

	localparam logic [63:0] REC_SEC64 = ((64'd1 << 31) + 64'd124) / 64'd125;
	localparam logic [24:0] REC_SEC = REC_SEC64[24:0];
	localparam logic [63:0] REC_HR64 = ((64'd1 << 21) + 64'd224) / 64'd225;
	localparam logic [13:0] REC_HR = REC_HR64[13:0];
	localparam logic [63:0] REC_MIN64 = ((64'd1 << 14) + 64'd14) / 64'd15;
	localparam logic [10:0] REC_MIN = REC_MIN64[10:0];

	localparam logic [16:0] SEC_HOUR = 17'd3600;
	localparam logic [11:0] SEC_MIN = 12'd60;

	// days since 0000-03-01 for 0001-01-01
	localparam logic [21:0] MAR_OFS = 22'd306;
	localparam logic [21:0] DAYS_400Y = 22'd146097;
	localparam logic [17:0] DAYS_100Y = 18'd36524;
	localparam logic [17:0] DAYS_LAST = 18'd146096;
	localparam logic [63:0] REC_ERA64 = ((64'd1 << 40) + 64'd146096) / 64'd146097;
	localparam logic [22:0] REC_ERA = REC_ERA64[22:0];
	localparam logic [63:0] REC_4Y64 = ((64'd1 << 29) + 64'd1459) / 64'd1460;
	localparam logic [18:0] REC_4Y = REC_4Y64[18:0];
	localparam logic [63:0] REC_YR64 = ((64'd1 << 27) + 64'd364) / 64'd365;
	localparam logic [18:0] REC_YR = REC_YR64[18:0];
	localparam logic [17:0] DAYS_YEAR = 18'd365;
	localparam logic [13:0] YEARS_ERA = 14'd400;

	// first day of each month, year starting in march
	localparam logic [8:0] MON_START [12] = '{
		9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
		9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
	};
	localparam logic [3:0] MP_JAN = 4'd10;

	typedef struct packed {
		logic [4:0] hour;
		logic [5:0] minute;
		logic [5:0] second;
	} tod_t;

	typedef struct packed {
		logic [13:0] year;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [2:0]  weekday;
	} date_t;

endpackage

>>> hdl/epoch_ms_to_utc_civil_date.sv
// ----------------------------------------------------------------------------
// epoch_ms_to_utc_civil_date
// Converts signed Unix milliseconds to the UTC calendar date and time of day
// (proleptic Gregorian, no leap seconds, weekday 0 is Sunday). Milliseconds
// truncate toward zero. Inputs outside years 1..9999 return all fields zero
// with tuser low. The datapath is a 15-stage pipeline with no shared unit:
// one transaction is accepted every clock unless the pipeline is full and
// the output is stalled, and each result is registered through stages 1 to
// 15 in order before it is offered on the output. Each stage holds its item
// only while the stage after it is full and stalled, so empty stages keep
// accepting input while a result waits at the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_ms_to_utc_civil_date import epc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // timestamp_ms[48:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// year[13:0] month[17:14] day[22:18] hour[27:23] minute[33:28]
	// second[39:34] weekday[42:40]
	output logic [47:0] m_axis_tdata,
	output logic        m_axis_tuser   // valid_res
);

	stg_en_t            ce;
	logic [NSTG:1]      vld_q;
	logic signed [48:0] ts_s1;
	logic               ok_s5;
	logic [21:0]        days_s5;
	logic [26:0]        rem_s5;
	logic [14:6]        ok_q;
	tod_t               tod_s14;
	date_t              date_s14;
	logic [47:0]        tdata_s15;
	logic               ok_s15;

	always_comb begin
		ce[NSTG] = !vld_q[NSTG] || m_axis_tready;
		for (int k = NSTG - 1; k >= 1; k--) begin
			ce[k] = !vld_q[k] || ce[k + 1];
		end
	end

	assign s_axis_tready = ce[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (ce[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (ce[k]) begin
					vld_q[k] <= vld_q[k - 1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce[1]) begin
			ts_s1 <= s_axis_tdata[48:0];
		end
	end

	epc_div u_div (
		.clk     (clk),
		.ce      (ce),
		.ts_s1   (ts_s1),
		.ok_s5   (ok_s5),
		.days_s5 (days_s5),
		.rem_s5  (rem_s5)
	);

	epc_tod u_tod (
		.clk     (clk),
		.ce      (ce),
		.rem_s5  (rem_s5),
		.tod_s14 (tod_s14)
	);

	epc_date u_date (
		.clk      (clk),
		.ce       (ce),
		.days_s5  (days_s5),
		.date_s14 (date_s14)
	);

	always_ff @(posedge clk) begin
		if (ce[6]) begin
			ok_q[6] <= ok_s5;
		end
		for (int k = 7; k <= 14; k++) begin
			if (ce[k]) begin
				ok_q[k] <= ok_q[k - 1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ce[NSTG]) begin
			ok_s15 <= ok_q[14];
			if (ok_q[14]) begin
				tdata_s15 <= {5'b00000, date_s14.weekday, tod_s14.second, tod_s14.minute,
					tod_s14.hour, date_s14.day, date_s14.month, date_s14.year};
			end else begin
				tdata_s15 <= '0;
			end
		end
	end

	assign m_axis_tvalid = vld_q[NSTG];
	assign m_axis_tdata  = tdata_s15;
	assign m_axis_tuser  = ok_s15;

endmodule

>>> hdl/epc_div.sv
// ----------------------------------------------------------------------------
// epc_div
// Range check and split of milliseconds into day number since 0001-01-01
// and milliseconds into the day.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_div import epc_pkg::*; (
	input  logic               clk,
	input  stg_en_t            ce,
	input  logic signed [48:0] ts_s1,
	output logic               ok_s5,
	output logic [21:0]        days_s5,
	output logic [26:0]        rem_s5
);

	logic        ok_s2, ok_s3, ok_s4;
	logic [48:0] v_s2;
	logic [54:0] prod_s3;
	logic [38:0] x_s3;
	logic [9:0]  lo_s3, lo_s4;
	logic [21:0] qe_s4;
	logic [17:0] qdl_s4, xl_s4;

	logic [49:0] vsum;
	logic        ok_c;
	logic [54:0] prod_c;
	logic [17:0] qdl_c, r_c;
	logic [21:0] q_c;
	logic [16:0] rf_c;

	always_comb begin
		ok_c = (ts_s1 >= MS_MIN) && (ts_s1 <= MS_MAX);
		// negative values round toward zero, so bias them by 999 ms
		vsum = {ts_s1[48], ts_s1} + (ts_s1[48] ? MS_OFS_NEG : MS_OFS);
	end

	always_ff @(posedge clk) begin
		if (ce[2]) begin
			ok_s2 <= ok_c;
			v_s2  <= vsum[48:0];
		end
	end

	// estimate of days, short by at most two
	assign prod_c = 55'(v_s2[48:17]) * 55'(DAY_K);

	always_ff @(posedge clk) begin
		if (ce[3]) begin
			ok_s3   <= ok_s2;
			prod_s3 <= prod_c;
			x_s3    <= v_s2[48:10];
			lo_s3   <= v_s2[9:0];
		end
	end

	assign qdl_c = prod_s3[49:32] * 18'(DAY_DIV);

	always_ff @(posedge clk) begin
		if (ce[4]) begin
			ok_s4  <= ok_s3;
			qe_s4  <= prod_s3[53:32];
			qdl_s4 <= qdl_c;
			xl_s4  <= x_s3[17:0];
			lo_s4  <= lo_s3;
		end
	end

	always_comb begin
		r_c = xl_s4 - qdl_s4;
		if (r_c >= 18'({DAY_DIV, 1'b0})) begin
			q_c  = qe_s4 + 22'd2;
			rf_c = 17'(r_c - 18'({DAY_DIV, 1'b0}));
		end else if (r_c >= 18'(DAY_DIV)) begin
			q_c  = qe_s4 + 22'd1;
			rf_c = 17'(r_c - 18'(DAY_DIV));
		end else begin
			q_c  = qe_s4;
			rf_c = r_c[16:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce[5]) begin
			ok_s5   <= ok_s4;
			days_s5 <= q_c;
			rem_s5  <= {rf_c, lo_s4};
		end
	end

endmodule

>>> hdl/epc_tod.sv
// ----------------------------------------------------------------------------
// epc_tod
// Milliseconds into the day to hour, minute and second.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_tod import epc_pkg::*; (
	input  logic        clk,
	input  stg_en_t     ce,
	input  logic [26:0] rem_s5,
	output tod_t        tod_s14
);

	logic [48:0] ps_s6;
	logic [26:0] ph_s7;
	logic [16:0] sod_s7;
	logic [4:0]  hour_s8, hour_s9;
	logic [11:0] rh_s8, rh_s9;
	logic [20:0] pm_s9;
	tod_t        tod_s10, tod_s11, tod_s12, tod_s13;

	logic [16:0] sod_c, rh_c;
	logic [4:0]  hour_c;
	logic [5:0]  min_c;
	logic [11:0] sec_c;

	always_ff @(posedge clk) begin
		if (ce[6]) begin
			ps_s6 <= 49'(rem_s5[26:3]) * 49'(REC_SEC);
		end
	end

	assign sod_c = ps_s6[47:31];

	always_ff @(posedge clk) begin
		if (ce[7]) begin
			ph_s7  <= 27'(sod_c[16:4]) * 27'(REC_HR);
			sod_s7 <= sod_c;
		end
	end

	always_comb begin
		hour_c = ph_s7[25:21];
		rh_c   = sod_s7 - 17'(hour_c) * SEC_HOUR;
	end

	always_ff @(posedge clk) begin
		if (ce[8]) begin
			hour_s8 <= hour_c;
			rh_s8   <= rh_c[11:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce[9]) begin
			pm_s9   <= 21'(rh_s8[11:2]) * 21'(REC_MIN);
			rh_s9   <= rh_s8;
			hour_s9 <= hour_s8;
		end
	end

	always_comb begin
		min_c = pm_s9[19:14];
		sec_c = rh_s9 - 12'(min_c) * SEC_MIN;
	end

	always_ff @(posedge clk) begin
		if (ce[10]) begin
			tod_s10.hour   <= hour_s9;
			tod_s10.minute <= min_c;
			tod_s10.second <= sec_c[5:0];
		end
		if (ce[11]) begin
			tod_s11 <= tod_s10;
		end
		if (ce[12]) begin
			tod_s12 <= tod_s11;
		end
		if (ce[13]) begin
			tod_s13 <= tod_s12;
		end
		if (ce[14]) begin
			tod_s14 <= tod_s13;
		end
	end

endmodule

>>> hdl/epc_date.sv
// ----------------------------------------------------------------------------
// epc_date
// Day number since 0001-01-01 to year, month, day and weekday using
// march-based 400-year eras.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_date import epc_pkg::*; (
	input  logic        clk,
	input  stg_en_t     ce,
	input  logic [21:0] days_s5,
	output date_t       date_s14
);

	logic [44:0] pe_s6;
	logic [21:0] z_s6;
	logic [5:0]  dsum_s6;
	logic [4:0]  era_s7, era_s8, era_s9, era_s10, era_s11, era_s12, era_s13;
	logic [2:0]  wd_s7, wd_s8, wd_s9, wd_s10, wd_s11, wd_s12, wd_s13;
	logic [17:0] doe_s7, doe_s8, doe_s9, doe_s10, doe_s11;
	logic [36:0] pa_s8, py_s10;
	logic [2:0]  b_s8;
	logic        c_s8;
	logic [17:0] n_s9;
	logic [8:0]  yoe_s11, yoe_s12, yoe_s13;
	logic [8:0]  doy_s12, doy_s13;
	logic [3:0]  mp_s13;

	logic [21:0] z_c, doe_c;
	logic [23:0] w_c;
	logic [5:0]  dsum_c;
	logic [4:0]  era_c;
	logic [3:0]  s2_c;
	logic [2:0]  wd_c;
	logic [1:0]  cent_c;
	logic [17:0] doy_c;
	logic [3:0]  mp_c;
	logic [8:0]  dd_c;

	always_comb begin
		z_c = days_s5 + MAR_OFS;
		// weekday of 0001-01-01 is monday; fold octal digits mod 7
		w_c = 24'(days_s5) + 24'd1;
		dsum_c = '0;
		for (int i = 0; i < 8; i++) begin
			dsum_c = dsum_c + 6'(w_c[3*i +: 3]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce[6]) begin
			pe_s6   <= 45'(z_c) * 45'(REC_ERA);
			z_s6    <= z_c;
			dsum_s6 <= dsum_c;
		end
	end

	always_comb begin
		era_c = pe_s6[44:40];
		doe_c = z_s6 - 22'(era_c) * DAYS_400Y;
		s2_c  = 4'(dsum_s6[5:3]) + 4'(dsum_s6[2:0]);
		if (s2_c >= 4'd14) begin
			wd_c = 3'(s2_c - 4'd14);
		end else if (s2_c >= 4'd7) begin
			wd_c = 3'(s2_c - 4'd7);
		end else begin
			wd_c = s2_c[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ce[7]) begin
			era_s7 <= era_c;
			doe_s7 <= doe_c[17:0];
			wd_s7  <= wd_c;
		end
	end

	always_ff @(posedge clk) begin
		if (ce[8]) begin
			pa_s8  <= 37'(doe_s7) * 37'(REC_4Y);
			b_s8   <= 3'(doe_s7 >= DAYS_100Y) + 3'(doe_s7 >= 18'({DAYS_100Y, 1'b0}))
				+ 3'(doe_s7 >= 18'(3 * DAYS_100Y)) + 3'(doe_s7 >= DAYS_LAST);
			c_s8   <= (doe_s7 == DAYS_LAST);
			doe_s8 <= doe_s7;
			era_s8 <= era_s7;
			wd_s8  <= wd_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (ce[9]) begin
			n_s9   <= doe_s8 - 18'(pa_s8[35:29]) + 18'(b_s8) - 18'(c_s8);
			doe_s9 <= doe_s8;
			era_s9 <= era_s8;
			wd_s9  <= wd_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (ce[10]) begin
			py_s10  <= 37'(n_s9) * 37'(REC_YR);
			doe_s10 <= doe_s9;
			era_s10 <= era_s9;
			wd_s10  <= wd_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (ce[11]) begin
			yoe_s11 <= py_s10[35:27];
			doe_s11 <= doe_s10;
			era_s11 <= era_s10;
			wd_s11  <= wd_s10;
		end
	end

	always_comb begin
		cent_c = 2'(yoe_s11 >= 9'd100) + 2'(yoe_s11 >= 9'd200) + 2'(yoe_s11 >= 9'd300);
		doy_c  = doe_s11 - (18'(yoe_s11) * DAYS_YEAR + 18'(yoe_s11[8:2]) - 18'(cent_c));
	end

	always_ff @(posedge clk) begin
		if (ce[12]) begin
			doy_s12 <= doy_c[8:0];
			yoe_s12 <= yoe_s11;
			era_s12 <= era_s11;
			wd_s12  <= wd_s11;
		end
	end

	always_comb begin
		mp_c = '0;
		for (int i = 1; i < 12; i++) begin
			mp_c = mp_c + 4'(doy_s12 >= MON_START[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ce[13]) begin
			mp_s13  <= mp_c;
			doy_s13 <= doy_s12;
			yoe_s13 <= yoe_s12;
			era_s13 <= era_s12;
			wd_s13  <= wd_s12;
		end
	end

	assign dd_c = doy_s13 - MON_START[mp_s13] + 9'd1;

	always_ff @(posedge clk) begin
		if (ce[14]) begin
			date_s14.year    <= 14'(yoe_s13) + 14'(era_s13) * YEARS_ERA
				+ 14'(mp_s13 >= MP_JAN);
			date_s14.month   <= (mp_s13 < MP_JAN) ? mp_s13 + 4'd3 : mp_s13 - 4'd9;
			date_s14.day     <= dd_c[4:0];
			date_s14.weekday <= wd_s13;
		end
	end

endmodule

>>> hdl/epc_checker.sv
// ----------------------------------------------------------------------------
// epc_checker
// Port-level checks for the epoch to civil date converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [55:0] s_axis_tdata,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [47:0] m_axis_tdata,
	input logic        m_axis_tuser
);

	// result stays offered until the transaction completes
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result dropped while stalled");

	// out-of-range input gives an all-zero result
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 48'd0)
		else $error("invalid result not zero");

	// in-range result has legal calendar fields
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
			m_axis_tdata[13:0] != 14'd0 && m_axis_tdata[13:0] <= 14'd9999 &&
			m_axis_tdata[17:14] != 4'd0 && m_axis_tdata[17:14] <= 4'd12 &&
			m_axis_tdata[22:18] != 5'd0 && m_axis_tdata[27:23] <= 5'd23 &&
			m_axis_tdata[33:28] <= 6'd59 && m_axis_tdata[39:34] <= 6'd59 &&
			m_axis_tdata[42:40] <= 3'd6 && m_axis_tdata[47:43] == 5'd0)
		else $error("result field out of range");

	// an empty output stage never blocks the input
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output");

	// a waiting input transaction stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
		else $error("input changed while waiting");

endmodule

bind epoch_ms_to_utc_civil_date epc_checker u_epc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
